[rtl/wpid_pkg.sv]
// Shared types, constants and helpers for the windowed PID controller.
package wpid_pkg;

    localparam int MAX_WINDOW = 8;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int DIV_W      = 38;   // |gain_d * diff * 16| + step/2 fits in 37 bits
    localparam int SAT_W      = 40;
    localparam int MIN_PRIMED = 3;

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_WINDOW = 2'd3;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [15:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic [DIV_W-1:0]   quot;
    } t_div_rsp;

    typedef struct packed {
        logic        clip;
        logic [15:0] val;
    } t_sat;

    // Saturate a sign/magnitude value to signed 16 bits.
    function automatic t_sat sat_mag(input logic neg, input logic [SAT_W-1:0] mag);
        t_sat r;
        logic [SAT_W-1:0] m_neg;
        m_neg  = -mag;
        r.clip = 1'b0;
        if (!neg) begin
            if (mag > SAT_W'(32767)) begin
                r.clip = 1'b1;
                r.val  = 16'h7FFF;
            end else begin
                r.val  = mag[15:0];
            end
        end else begin
            if (mag > SAT_W'(32768)) begin
                r.clip = 1'b1;
                r.val  = 16'h8000;
            end else begin
                r.val  = m_neg[15:0];
            end
        end
        return r;
    endfunction

endpackage

[rtl/wpid_hist_ram.sv]
// Sample history memory: one write port, one registered read port.
module wpid_hist_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/wpid_div.sv]
// Restoring divider, one quotient bit per cycle.
module wpid_div
    import wpid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [15:0]      r_rem;
    logic [15:0]      r_den;
    logic [16:0]      n_trial;
    logic             n_ge;
    logic [16:0]      n_diff;

    assign n_trial = {r_rem, r_q[DIV_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CW'(DIV_W);
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_q   <= {r_q[DIV_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[15:0] : n_trial[15:0];
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.quot = r_q;

endmodule

[rtl/windowed_pid_controller.sv]
// Windowed PID controller top level: control sequencer and term datapath.
//
// One request per item. A clear request (tuser = 1) empties the history and returns
// control 0. A push stores error and time step in an eight-entry circular history
// memory; with fewer than three held samples the result is zero, otherwise the
// block walks the window (one memory read per held sample) to form the sum of
// error * step, while a serial divider (one quotient bit per cycle) forms the
// derivative term. When the derivative needs a divide, the divider sets the rate
// from one primed push to the next. The next request is taken once the result
// sits in the output register; that register holds it until the master side takes
// it. Configuration writes are always ready and should be made only while the
// block is idle.
module windowed_pid_controller
    import wpid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] error_value, [31:16] time_step
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] control
    output logic [1:0]  m_axis_tuser,   // [0] primed, [1] saturated
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_IMUL_LO, ST_IMUL_HI, ST_TERMS, ST_SUM, ST_DONE
    } t_state;

    t_state r_state;

    logic signed [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [3:0]         r_wlen;

    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_rd;
    logic               r_vld;
    logic signed [15:0] r_e0;
    logic signed [35:0] r_acc;
    logic signed [34:0] r_ilo;
    logic signed [33:0] r_ihi;
    logic signed [31:0] r_pp;
    logic               r_d_div, r_d_zs, r_d_neg, r_d_nz;
    logic signed [15:0] r_pt, r_it, r_dt;
    logic               r_clip;

    // result register
    logic               r_out_valid;
    logic [15:0]        r_out_ctl;
    logic               r_out_primed, r_out_sat;
    logic [15:0]        r_res_ctl;
    logic               r_res_primed, r_res_sat;

    // input decode
    logic               n_accept, n_mode;
    logic signed [15:0] n_err;
    logic [15:0]        n_step;
    logic [3:0]         n_win;
    logic [CNT_W-1:0]   n_cnt;
    logic               n_primed;

    assign n_accept = s_axis_tvalid && s_axis_tready;
    assign n_mode   = s_axis_tuser[0];
    assign n_err    = $signed(s_axis_tdata[15:0]);
    assign n_step   = s_axis_tdata[31:16];

    // window clamp: zero acts as one, above the depth acts as the depth
    always_comb begin
        if (r_wlen == 4'd0) begin
            n_win = 4'd1;
        end else if (r_wlen > 4'(MAX_WINDOW)) begin
            n_win = 4'(MAX_WINDOW);
        end else begin
            n_win = r_wlen;
        end
        n_cnt    = (r_cnt < CNT_W'(n_win)) ? r_cnt + 1'b1 : CNT_W'(n_win);
        n_primed = (n_cnt >= CNT_W'(MIN_PRIMED));
    end

    // derivative numerator, formed as the sample arrives
    logic signed [16:0] n_diff;
    logic signed [32:0] n_gd_diff;
    logic [36:0]        n_dmag;
    logic [DIV_W-1:0]   n_dividend;
    t_div_req           n_div_req;
    t_div_rsp           w_div_rsp;

    assign n_diff     = 17'(n_err) - 17'(r_e0);
    assign n_gd_diff  = 33'(r_gain_d) * 33'(n_diff);
    assign n_dmag     = n_gd_diff[32] ? 37'(-n_gd_diff) << 4 : 37'(n_gd_diff) << 4;
    assign n_dividend = DIV_W'(n_dmag) + DIV_W'(n_step >> 1);

    assign n_div_req.start    = n_accept && (n_mode == MODE_PUSH) && n_primed
                                && (r_gain_d != '0) && (n_step != '0);
    assign n_div_req.dividend = n_dividend;
    assign n_div_req.divisor  = n_step;

    wpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (w_div_rsp)
    );

    // history memory: {step, error}, newest at r_head
    logic               n_we, n_re;
    logic [PTR_W-1:0]   n_waddr, n_raddr;
    logic [31:0]        w_rdata;

    assign n_we    = n_accept && (n_mode == MODE_PUSH);
    assign n_waddr = r_head + 1'b1;
    assign n_re    = (r_state == ST_WALK) && (r_rd != r_cnt);
    assign n_raddr = r_head - r_rd[PTR_W-1:0];

    wpid_hist_ram #(.DEPTH(MAX_WINDOW), .WIDTH(32)) u_hist (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata ({n_step, n_err}),
        .i_re    (n_re),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // error * step for the entry read last cycle
    logic signed [32:0] n_es;
    assign n_es = 33'($signed(w_rdata[15:0])) * $signed({1'b0, w_rdata[31:16]});

    // term rounding (to nearest, ties away from zero) and saturation
    logic signed [53:0] n_ifull;
    logic [53:0]        n_imag;
    logic [53:0]        n_iq;
    logic [31:0]        n_pmag;
    logic [32:0]        n_pq;
    t_sat               n_p_sat, n_i_sat, n_d_sat;
    logic signed [17:0] n_sum;
    t_sat               n_sum_sat;

    always_comb begin
        n_ifull = (54'(r_ihi) <<< 18) + 54'(r_ilo);
        n_imag  = n_ifull[53] ? -n_ifull : n_ifull;
        n_iq    = (n_imag + (54'(1) << 27)) >> 28;
        n_i_sat = sat_mag(n_ifull[53], SAT_W'(n_iq[25:0]));

        n_pmag  = r_pp[31] ? -r_pp : r_pp;
        n_pq    = (33'(n_pmag) + 33'd2048) >> 12;
        n_p_sat = sat_mag(r_pp[31], SAT_W'(n_pq[20:0]));

        if (r_d_div) begin
            n_d_sat = sat_mag(r_d_neg, SAT_W'(w_div_rsp.quot));
        end else if (r_d_zs) begin
            n_d_sat.clip = 1'b1;
            n_d_sat.val  = !r_d_nz ? 16'h0000 : (r_d_neg ? 16'h8000 : 16'h7FFF);
        end else begin
            n_d_sat.clip = 1'b0;
            n_d_sat.val  = 16'h0000;
        end

        n_sum = 18'(r_pt) + 18'(r_it) + 18'(r_dt);
        if (n_sum > 18'sd32767) begin
            n_sum_sat.clip = 1'b1;
            n_sum_sat.val  = 16'h7FFF;
        end else if (n_sum < -18'sd32768) begin
            n_sum_sat.clip = 1'b1;
            n_sum_sat.val  = 16'h8000;
        end else begin
            n_sum_sat.clip = 1'b0;
            n_sum_sat.val  = n_sum[15:0];
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain_p    <= 16'sd410;
            r_gain_i    <= 16'sd0;
            r_gain_d    <= 16'sd205;
            r_wlen      <= 4'd5;
            r_head      <= '0;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_vld       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GAIN_P: r_gain_p <= $signed(i_cfg_data);
                    REG_GAIN_I: r_gain_i <= $signed(i_cfg_data);
                    REG_GAIN_D: r_gain_d <= $signed(i_cfg_data);
                    REG_WINDOW: r_wlen   <= i_cfg_data[3:0];
                    default:    ;
                endcase
            end

            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_res_ctl    <= '0;
                        r_res_primed <= 1'b0;
                        r_res_sat    <= 1'b0;
                        if (n_mode == MODE_CLEAR) begin
                            r_cnt   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_head  <= n_waddr;
                            r_e0    <= n_err;
                            r_cnt   <= n_cnt;
                            r_d_div <= (r_gain_d != '0) && (n_step != '0);
                            r_d_zs  <= (r_gain_d != '0) && (n_step == '0);
                            r_d_neg <= n_gd_diff[32];
                            r_d_nz  <= (n_gd_diff != '0);
                            r_rd    <= '0;
                            r_vld   <= 1'b0;
                            r_acc   <= '0;
                            r_state <= n_primed ? ST_WALK : ST_DONE;
                        end
                    end
                end
                ST_WALK: begin
                    if (r_rd != r_cnt) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    r_vld <= n_re;
                    if (r_vld) begin
                        r_acc <= r_acc + 36'(n_es);
                    end
                    if ((r_rd == r_cnt) && !r_vld) begin
                        r_state <= ST_IMUL_LO;
                    end
                end
                ST_IMUL_LO: begin
                    r_ilo   <= 35'(r_gain_i) * $signed({1'b0, r_acc[17:0]});
                    r_pp    <= 32'(r_gain_p) * 32'(r_e0);
                    r_state <= ST_IMUL_HI;
                end
                ST_IMUL_HI: begin
                    r_ihi   <= 34'(r_gain_i) * 34'($signed(r_acc[35:18]));
                    r_state <= ST_TERMS;
                end
                ST_TERMS: begin
                    if (!w_div_rsp.busy) begin
                        r_pt    <= $signed(n_p_sat.val);
                        r_it    <= $signed(n_i_sat.val);
                        r_dt    <= $signed(n_d_sat.val);
                        r_clip  <= n_p_sat.clip || n_i_sat.clip || n_d_sat.clip;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_res_ctl    <= n_sum_sat.val;
                    r_res_primed <= 1'b1;
                    r_res_sat    <= r_clip || n_sum_sat.clip;
                    r_state      <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_ctl    <= r_res_ctl;
                        r_out_primed <= r_res_primed;
                        r_out_sat    <= r_res_sat;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_ctl;
    assign m_axis_tuser  = {r_out_sat, r_out_primed};

endmodule

[dv/testbench.sv]
// Self-checking testbench for the windowed PID controller.
module testbench;
    import wpid_pkg::*;

    typedef struct {
        logic [15:0] control;
        logic        primed;
        logic        saturated;
    } t_ctrl_out;

    // scoreboard: PID predictor plus queue of pending control results
    class pid_scoreboard;
        logic [15:0] err_hist [MAX_WINDOW];
        logic [15:0] step_hist [MAX_WINDOW];
        int unsigned held;
        logic [15:0] kp, ki, kd;
        logic [3:0]  win_len;
        t_ctrl_out   pending [$];
        int          errors;

        function void init();
            foreach (err_hist[i]) begin
                err_hist[i]  = '0;
                step_hist[i] = '0;
            end
            held = 0; kp = 16'd410; ki = 16'd0; kd = 16'd205; win_len = 4'd5;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_GAIN_P: kp = val;
                REG_GAIN_I: ki = val;
                REG_GAIN_D: kd = val;
                REG_WINDOW: win_len = val[3:0];
                default: ;
            endcase
        endfunction

        // round to nearest, ties away from zero
        function longint rdiv(longint n, longint d);
            longint m, q;
            m = (n < 0) ? -n : n;
            q = (m + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function longint clip16(longint v, ref bit clip);
            if (v > 32767) begin
                clip = 1; return 32767;
            end
            if (v < -32768) begin
                clip = 1; return -32768;
            end
            return v;
        endfunction

        function void note_request(logic mode, logic [15:0] err, logic [15:0] step);
            t_ctrl_out r;
            int unsigned w;
            bit clip;
            longint p, it, d, acc, dif, num;
            r = '{16'd0, 1'b0, 1'b0};
            clip = 0;
            if (mode == MODE_CLEAR) begin
                held = 0;
                pending.push_back(r);
                return;
            end
            w = (win_len < 1) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
                err_hist[i]  = err_hist[i-1];
                step_hist[i] = step_hist[i-1];
            end
            err_hist[0] = err; step_hist[0] = step;
            if (held < w) held++;
            if (held > w) held = w;
            if (held >= 3) begin
                p = longint'($signed(kp)) * longint'($signed(err_hist[0]));
                p = clip16(rdiv(p, 4096), clip);
                acc = 0;
                for (int i = 0; i < held; i++)
                    acc += longint'($signed(err_hist[i])) * longint'(step_hist[i]);
                it = clip16(rdiv(longint'($signed(ki)) * acc, longint'(1) << 28), clip);
                d = 0;
                if (kd != 0) begin
                    dif = longint'($signed(err_hist[0])) - longint'($signed(err_hist[1]));
                    num = longint'($signed(kd)) * dif * 16;
                    if (step_hist[0] == 0) begin
                        clip = 1;
                        d = (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
                    end else begin
                        d = clip16(rdiv(num, longint'(step_hist[0])), clip);
                    end
                end
                r.control   = 16'(clip16(p + it + d, clip));
                r.primed    = 1'b1;
                r.saturated = clip;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] ctl, logic prm, logic sat);
            t_ctrl_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result control=%h", $time, ctl);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ctl !== e.control) begin
                $display("%0t: control exp %h got %h", $time, e.control, ctl);
                errors++;
            end
            if (prm !== e.primed) begin
                $display("%0t: primed exp %b got %b", $time, e.primed, prm);
                errors++;
            end
            if (sat !== e.saturated) begin
                $display("%0t: saturated exp %b got %b", $time, e.saturated, sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] error_value, [31:16] time_step
    logic [0:0]  s_axis_tuser = '0;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] control
    logic [1:0]  m_axis_tuser;        // [0] primed, [1] saturated
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    pid_scoreboard sb;
    bit            stim_done = 0;
    bit            stall_free = 0;

    windowed_pid_controller i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    task automatic send_request(logic mode, logic [15:0] err, logic [15:0] step);
        int g;
        g = stall_free ? 0 : gap_len();
        repeat (g) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {step, err};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(mode, err, step);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_err();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 1024)) - 512);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'd0;
            3: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random back-pressure (none in stall-free phases), checks each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            m_axis_tready <= stall_free ? 1'b1 : ($urandom_range(0, 99) < 65);
        end
    end

    initial begin
        sb = new();
        sb.init();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, priming, clear, zero step, extremes
        send_request(MODE_PUSH, 16'h0100, 16'h1000);
        send_request(MODE_PUSH, 16'h0200, 16'h1000);
        send_request(MODE_PUSH, 16'h0300, 16'h1000);
        send_request(MODE_PUSH, 16'h7FFF, 16'h0000);
        send_request(MODE_PUSH, 16'h8000, 16'h0000);
        send_request(MODE_PUSH, 16'h8000, 16'h0000);
        send_request(MODE_PUSH, 16'h7FFF, 16'hFFFF);
        send_request(MODE_PUSH, 16'h8000, 16'h0001);
        send_request(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
        send_request(MODE_PUSH, 16'h0000, 16'h0000);
        drain();
        write_reg(REG_GAIN_P, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'h7FFF);
        write_reg(REG_GAIN_D, 16'h0000);
        write_reg(REG_WINDOW, 16'd8);
        for (int k = 0; k < 9; k++)
            send_request(MODE_PUSH, 16'h7FFF, 16'hFFFF);
        send_request(MODE_PUSH, 16'h8000, 16'h0000);
        drain();
        write_reg(REG_GAIN_P, 16'h8000);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_WINDOW, 16'd0);
        send_request(MODE_PUSH, 16'h1234, 16'h0000);
        send_request(MODE_PUSH, 16'h4321, 16'h0000);
        drain();
        write_reg(REG_WINDOW, 16'd15);

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 27; ph++) begin
            write_reg(REG_GAIN_P, rand_gain());
            write_reg(REG_GAIN_I, rand_gain());
            write_reg(REG_GAIN_D, rand_gain());
            write_reg(REG_WINDOW, 16'($urandom_range(0, 15)));
            stall_free = (ph % 5 == 2);
            for (int k = 0; k < 50; k++) begin
                // clears are rare so most runs reach the primed window
                if ($urandom_range(0, 29) == 0)
                    send_request(MODE_CLEAR, 16'($urandom), 16'($urandom));
                else
                    send_request(MODE_PUSH, rand_err(), rand_step());
                if (k == 25 && ph % 4 == 0)
                    while (sb.pending.size() != 0) @(posedge i_clk);
            end
            drain();
            stall_free = 0;
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("windowed_pid_controller: match");
        else
            $display("windowed_pid_controller: mismatch");
        $finish;
    end

    initial begin
        #10000000;
        $display("windowed_pid_controller: mismatch");
        $finish;
    end
endmodule

[sim.f]
rtl/wpid_pkg.sv
rtl/wpid_hist_ram.sv
rtl/wpid_div.sv
rtl/windowed_pid_controller.sv
dv/testbench.sv
